// ===== design/dbtm_pkg.sv =====
// Package for the diamond blur with texture blend.
// Holds the column record, the cell control and blend stage types and the arithmetic constants.
// No dependencies.
package dbtm_pkg;

    localparam int N_CELLS     = 4;
    localparam int CH_W        = 8;
    localparam int SUM_W       = 12;
    localparam int DIV14_SHIFT = 16;
    localparam int PROD_W      = 25;

    // ceil(2^16 / 14); exact for every sum below 5461, and the sum never exceeds 3570.
    localparam logic [12:0] DIV14_MUL = 13'd4682;
    localparam logic [7:0]  ALPHA_MAX = 8'd255;

    // One column of the five-row stripe.
    typedef struct packed {
        logic [23:0] c;
        logic [23:0] m1;
        logic [23:0] p1;
        logic [23:0] m2;
        logic [23:0] p2;
        logic [7:0]  ta;
    } t_col;

    typedef struct packed {
        logic shift;
        logic fill;
    } t_cell_ctl;

    // Raw diamond sums handed to the blend pipeline; index 2 is red.
    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [23:0]           centre;
        logic [7:0]            ta;
        logic                  last;
    } t_sum;

endpackage

// ===== design/dbtm_cfg_if.sv =====
// Configuration write channel of the diamond blur block.
// Carries the texture enable bit. No dependencies.
interface dbtm_cfg_if;
    logic valid;
    logic ready;
    logic texture_enable;

    modport source (output valid, output texture_enable, input ready);
    modport sink   (input valid, input texture_enable, output ready);
endinterface

// ===== design/dbtm_in_if.sv =====
// Input column channel of the diamond blur block.
// Carries five RGB pixels, the texture alpha and the row-end mark. No dependencies.
interface dbtm_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_row_minus2;
    logic [23:0] pixel_row_minus1;
    logic [23:0] pixel_row_centre;
    logic [23:0] pixel_row_plus1;
    logic [23:0] pixel_row_plus2;
    logic [7:0]  tex_alpha;
    logic        row_end;

    modport source (output valid, output pixel_row_minus2, output pixel_row_minus1,
                    output pixel_row_centre, output pixel_row_plus1, output pixel_row_plus2,
                    output tex_alpha, output row_end, input ready);
    modport sink   (input valid, input pixel_row_minus2, input pixel_row_minus1,
                    input pixel_row_centre, input pixel_row_plus1, input pixel_row_plus2,
                    input tex_alpha, input row_end, output ready);
endinterface

// ===== design/dbtm_out_if.sv =====
// Result channel of the diamond blur block.
// Carries the ARGB pixel and the last-of-row mark. No dependencies.
interface dbtm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        last_of_row;

    modport source (output valid, output out_pixel, output last_of_row, input ready);
    modport sink   (input valid, input out_pixel, input last_of_row, output ready);
endinterface

// ===== design/dbtm_cell.sv =====
// One window cell: holds one column of the stripe.
// Depends on dbtm_pkg.
module dbtm_cell
    import dbtm_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_col      i_prev,
    input  t_col      i_fill_col,
    output t_col      o_col
);

    t_col r_col;

    // At a row start every cell takes the first column, which clamps the left edge.
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_col <= i_fill_col;
        end else if (i_ctl.shift) begin
            r_col <= i_prev;
        end
    end

    assign o_col = r_col;

endmodule

// ===== design/dbtm_blend.sv =====
// Divide and blend pipeline: sum register, divide by 14, alpha products, output register.
// Depends on dbtm_pkg and dbtm_out_if.
module dbtm_blend
    import dbtm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tex,
    input  t_sum              i_sum,
    input  logic              i_sum_valid,
    output logic              o_sum_ready,
    dbtm_out_if.source        o_pix_out
);

    // Stage 1: sums.
    logic r_v1;
    t_sum r_s1;
    // Stage 2: quotients.
    logic                 r_v2;
    logic [2:0][CH_W-1:0] r_q2;
    logic [23:0]          r_c2;
    logic [7:0]           r_ta2;
    logic                 r_last2;
    // Stage 3: blend products.
    logic                   r_v3;
    logic [2:0][CH_W-1:0]   r_q3;
    logic [2:0][2*CH_W-1:0] r_pc3;
    logic [2:0][2*CH_W-1:0] r_pb3;
    logic [7:0]             r_as3;
    logic                   r_last3;
    // Stage 4: output word.
    logic        r_v4;
    logic [31:0] r_pix4;
    logic        r_last4;

    logic adv1, adv2, adv3, adv4;
    logic [2:0][CH_W-1:0]   n_q2;
    logic [2:0][2*CH_W-1:0] n_pc3;
    logic [2:0][2*CH_W-1:0] n_pb3;
    logic [7:0]             n_as3;
    logic [2:0][CH_W-1:0]   n_ch4;
    logic [PROD_W-1:0]      w_prod;

    assign adv4 = !r_v4 || o_pix_out.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_sum_ready = adv1;

    always_comb begin
        w_prod = '0;
        n_q2   = '0;
        for (int k = 0; k < 3; k++) begin
            w_prod  = PROD_W'(r_s1.sum[k]) * PROD_W'(DIV14_MUL);
            n_q2[k] = w_prod[DIV14_SHIFT +: CH_W];
        end
    end

    // 255 - as is the texture alpha itself.
    always_comb begin
        n_as3 = ALPHA_MAX - r_ta2;
        for (int k = 0; k < 3; k++) begin
            n_pc3[k] = (2*CH_W)'(r_c2[8*k +: CH_W]) * (2*CH_W)'(n_as3);
            n_pb3[k] = (2*CH_W)'(r_q2[k]) * (2*CH_W)'(r_ta2);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ch4[k] = i_tex ? CH_W'(r_pc3[k][15:8] + r_pb3[k][15:8]) : r_q3[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_sum_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= i_sum;
        end
        if (adv2) begin
            r_q2    <= n_q2;
            r_c2    <= r_s1.centre;
            r_ta2   <= r_s1.ta;
            r_last2 <= r_s1.last;
        end
        if (adv3) begin
            r_q3    <= r_q2;
            r_pc3   <= n_pc3;
            r_pb3   <= n_pb3;
            r_as3   <= n_as3;
            r_last3 <= r_last2;
        end
        if (adv4) begin
            r_pix4  <= {(i_tex ? r_as3 : ALPHA_MAX), n_ch4[2], n_ch4[1], n_ch4[0]};
            r_last4 <= r_last3;
        end
    end

    assign o_pix_out.valid       = r_v4;
    assign o_pix_out.out_pixel   = r_pix4;
    assign o_pix_out.last_of_row = r_last4;

endmodule

// ===== design/diamond_blur_texture_mix_top.sv =====
// Top level of the diamond blur with texture blend.
// Depends on dbtm_pkg, the three channel interfaces, dbtm_cell and dbtm_blend.
//
//  Channel    Modport  Word                                     Notes
//  i_cfg      sink     texture_enable                           always ready
//  i_pix_in   sink     five RGB pixels, tex_alpha, row_end      one column per word
//  o_pix_out  source   out_pixel (ARGB), last_of_row            result of column x-2
//
// One column is taken per cycle while the blend pipeline accepts and no flush is running;
// after a row-end column the window sequencer replays it twice to flush the row's last two
// results (one for a one-column row) while input ready is low. A result passes through the
// sum, quotient, product and output registers; the flushed results of a row end follow it.
// Reset clears the sequencer, the pipeline valid bits and texture_enable; the window cells
// are loaded by the first column of each row. A stalled output stops each stage only
// once the stage after it is full, so the block keeps taking columns into empty stages.
module diamond_blur_texture_mix_top
    import dbtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbtm_cfg_if.sink    i_cfg,
    dbtm_in_if.sink     i_pix_in,
    dbtm_out_if.source  o_pix_out
);

    localparam logic [1:0] FL_IDLE   = 2'd0;
    localparam logic [1:0] FL_LAST   = 2'd1;
    localparam logic [1:0] FL_SECOND = 2'd2;

    logic       r_tex;
    logic [1:0] r_col_cnt;
    logic [1:0] r_flush;
    logic       r_flush_c1;
    t_col       r_hold;

    t_col      w_in_col;
    t_col      n_col;
    t_col      w_cells [N_CELLS];
    t_col      w_prev  [N_CELLS];
    t_col      w_tap   [N_CELLS];
    t_cell_ctl w_ctl;
    t_sum      w_sum;
    logic      w_sum_valid;
    logic      w_sum_ready;
    logic      flushing, accept, flush_issue, issue, row_start, emit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex <= 1'b0;
        end else if (i_cfg.valid) begin
            r_tex <= i_cfg.texture_enable;
        end
    end

    assign w_in_col = '{c:  i_pix_in.pixel_row_centre,
                        m1: i_pix_in.pixel_row_minus1,
                        p1: i_pix_in.pixel_row_plus1,
                        m2: i_pix_in.pixel_row_minus2,
                        p2: i_pix_in.pixel_row_plus2,
                        ta: i_pix_in.tex_alpha};

    assign flushing       = (r_flush != FL_IDLE);
    assign i_pix_in.ready = w_sum_ready && !flushing;
    assign accept         = i_pix_in.valid && i_pix_in.ready;
    assign flush_issue    = flushing && w_sum_ready;
    assign issue          = accept || flush_issue;
    assign n_col          = flushing ? r_hold : w_in_col;
    assign row_start      = accept && (r_col_cnt == 2'd0);

    always_comb begin
        priority if (accept) begin
            emit = r_col_cnt[1];
        end else if (r_flush == FL_SECOND) begin
            emit = r_flush_c1;
        end else begin
            emit = 1'b1;
        end
    end

    // Sequencer: column count, and the two replays of the row-end column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= 2'd0;
            r_flush    <= FL_IDLE;
            r_flush_c1 <= 1'b0;
        end else if (accept) begin
            if (i_pix_in.row_end) begin
                r_flush    <= FL_SECOND;
                r_flush_c1 <= (r_col_cnt != 2'd0);
                r_col_cnt  <= 2'd0;
            end else if (!r_col_cnt[1]) begin
                r_col_cnt <= r_col_cnt + 2'd1;
            end
        end else if (flush_issue) begin
            r_flush <= (r_flush == FL_SECOND) ? FL_LAST : FL_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= w_in_col;
        end
    end

    // The cell chain: cell 0 holds the oldest column, the new column enters at the top.
    assign w_ctl = '{shift: issue, fill: row_start};

    always_comb begin
        for (int i = 0; i < N_CELLS - 1; i++) begin
            w_prev[i] = w_cells[i+1];
        end
        w_prev[N_CELLS-1] = n_col;
        for (int i = 0; i < N_CELLS; i++) begin
            w_tap[i] = row_start ? n_col : w_cells[i];
        end
    end

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        dbtm_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_prev     (w_prev[g]),
            .i_fill_col (n_col),
            .o_col      (w_cells[g])
        );
    end

    function automatic logic [SUM_W-1:0] ext(input logic [23:0] pix, input int k);
        return SUM_W'(pix[8*k +: CH_W]);
    endfunction

    // Diamond taps around the centre column held in cell 2.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum.sum[k] = ext(w_tap[0].c, k) + ext(w_tap[1].c, k) + ext(w_tap[2].c, k)
                         + ext(w_tap[3].c, k) + ext(n_col.c, k)
                         + ext(w_tap[1].m1, k) + (ext(w_tap[2].m1, k) << 1)
                         + ext(w_tap[3].m1, k)
                         + ext(w_tap[1].p1, k) + ext(w_tap[2].p1, k) + ext(w_tap[3].p1, k)
                         + ext(w_tap[2].m2, k) + ext(w_tap[2].p2, k);
        end
        w_sum.centre = w_tap[2].c;
        w_sum.ta     = w_tap[2].ta;
        w_sum.last   = (r_flush == FL_LAST);
    end

    assign w_sum_valid = issue && emit;

    dbtm_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tex       (r_tex),
        .i_sum       (w_sum),
        .i_sum_valid (w_sum_valid),
        .o_sum_ready (w_sum_ready),
        .o_pix_out   (o_pix_out)
    );

endmodule
